FILE: rtl/http_byte_range_parser_defines.svh
// Assertion helpers for the byte range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HBRP_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define HBRP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hbrp_pkg.sv
package hbrp_pkg;

   // Fixed field widths
   localparam int SIZE_BITS          = 63;
   localparam int VALUE_BITS_DEFAULT = 63;
   localparam int REQ_TDATA_BITS     = 72;   // byte_valid, header_byte, resource_size
   localparam int RSP_TDATA_BITS     = 128;  // accepted, range_start, range_length, pad

   // Character codes
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Decimal base of the token accumulators
   localparam int DEC_BASE = 10;

   // Length of the "bytes=" unit prefix
   localparam logic [2:0] PREFIX_LEN = 3'd6;

   // Parser state captured on the last item of a header
   typedef struct packed {
      logic                 bad;
      logic                 prefix_done;
      logic                 dash;
      logic                 first_ne;
      logic                 second_ne;
      logic [SIZE_BITS-1:0] first_val;
      logic [SIZE_BITS-1:0] second_val;
      logic [SIZE_BITS-1:0] size;
   } snap_type;

   // Expected prefix character at each position
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h62;  // b
         3'd1:    c = 8'h79;  // y
         3'd2:    c = 8'h74;  // t
         3'd3:    c = 8'h65;  // e
         3'd4:    c = 8'h73;  // s
         3'd5:    c = 8'h3D;  // =
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/hbrp_scan.sv
module hbrp_scan #(
   parameter int VALUE_BITS = hbrp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic                           byte_valid,
   input  logic [7:0]                     header_byte,
   input  logic                           last,
   input  logic [hbrp_pkg::SIZE_BITS-1:0] resource_size,
   output logic                           snap_valid,
   input  logic                           snap_ready,
   output hbrp_pkg::snap_type             snap
);
   import hbrp_pkg::*;

   localparam int WIDE_BITS = VALUE_BITS + 4;

   logic [2:0]            prefix_count_ff, prefix_count_in;
   logic                  dash_ff, dash_in;
   logic                  first_ne_ff, first_ne_in;
   logic                  second_ne_ff, second_ne_in;
   logic                  bad_ff, bad_in;
   logic [VALUE_BITS-1:0] first_val_ff, first_val_in;
   logic [VALUE_BITS-1:0] second_val_ff, second_val_in;
   logic                  snap_valid_ff, snap_valid_in;
   snap_type              snap_ff, snap_in;

   logic                  accept;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [7:0]            digit_byte;
   logic [VALUE_BITS-1:0] acc_sel;
   logic [WIDE_BITS-1:0]  acc_wide;
   logic [WIDE_BITS-1:0]  acc_next;
   logic                  acc_ovf;

   // Hold the item while a finished header waits downstream
   assign in_ready = !snap_valid_ff || snap_ready;
   assign accept   = in_valid && in_ready;

   // Digit accumulate: acc*10 + d as shift and add, overflow above the value width
   assign digit_byte = header_byte - CHAR_ZERO;
   assign digit      = digit_byte[3:0];
   assign is_digit   = (header_byte >= CHAR_ZERO) && (header_byte <= CHAR_NINE);
   assign acc_sel    = dash_ff ? second_val_ff : first_val_ff;
   assign acc_wide   = {4'b0000, acc_sel};
   assign acc_next   = (acc_wide << 3) + (acc_wide << 1)
                       + {{(WIDE_BITS-4){1'b0}}, digit};
   assign acc_ovf    = |acc_next[WIDE_BITS-1:VALUE_BITS];

   // Next parser state for one header byte
   always_comb begin
      prefix_count_in = prefix_count_ff;
      dash_in         = dash_ff;
      first_ne_in     = first_ne_ff;
      second_ne_in    = second_ne_ff;
      bad_in          = bad_ff;
      first_val_in    = first_val_ff;
      second_val_in   = second_val_ff;
      if (byte_valid && !bad_ff) begin
         if (prefix_count_ff < PREFIX_LEN) begin
            if (header_byte == prefix_char(prefix_count_ff)) begin
               prefix_count_in = prefix_count_ff + 3'd1;
            end else begin
               bad_in = 1'b1;
            end
         end else if (header_byte == CHAR_DASH) begin
            if (dash_ff) begin
               bad_in = 1'b1;
            end else begin
               dash_in = 1'b1;
            end
         end else if (is_digit) begin
            if (dash_ff) begin
               second_ne_in = 1'b1;
            end else begin
               first_ne_in = 1'b1;
            end
            if (acc_ovf) begin
               bad_in = 1'b1;
            end else if (dash_ff) begin
               second_val_in = acc_next[VALUE_BITS-1:0];
            end else begin
               first_val_in = acc_next[VALUE_BITS-1:0];
            end
         end else if (header_byte == CHAR_COMMA) begin
            // range list: only a single range is supported
            bad_in = 1'b1;
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   // Snapshot of the finished header
   always_comb begin
      snap_in.bad         = bad_in;
      snap_in.prefix_done = (prefix_count_in == PREFIX_LEN);
      snap_in.dash        = dash_in;
      snap_in.first_ne    = first_ne_in;
      snap_in.second_ne   = second_ne_in;
      snap_in.first_val   = SIZE_BITS'(first_val_in);
      snap_in.second_val  = SIZE_BITS'(second_val_in);
      snap_in.size        = resource_size;
      if (accept && last) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   // State registers, cleared after each last item
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_count_ff <= '0;
         dash_ff         <= 1'b0;
         first_ne_ff     <= 1'b0;
         second_ne_ff    <= 1'b0;
         bad_ff          <= 1'b0;
         first_val_ff    <= '0;
         second_val_ff   <= '0;
         snap_valid_ff   <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (accept) begin
            if (last) begin
               prefix_count_ff <= '0;
               dash_ff         <= 1'b0;
               first_ne_ff     <= 1'b0;
               second_ne_ff    <= 1'b0;
               bad_ff          <= 1'b0;
               first_val_ff    <= '0;
               second_val_ff   <= '0;
            end else begin
               prefix_count_ff <= prefix_count_in;
               dash_ff         <= dash_in;
               first_ne_ff     <= first_ne_in;
               second_ne_ff    <= second_ne_in;
               bad_ff          <= bad_in;
               first_val_ff    <= first_val_in;
               second_val_ff   <= second_val_in;
            end
         end
      end
   end

   // Snapshot payload
   always_ff @(posedge clock) begin
      if (accept && last) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

FILE: rtl/hbrp_finish.sv
module hbrp_finish (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           snap_valid,
   output logic                           snap_ready,
   input  hbrp_pkg::snap_type             snap,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_accepted,
   output logic [hbrp_pkg::SIZE_BITS-1:0] out_start,
   output logic [hbrp_pkg::SIZE_BITS-1:0] out_length
);
   import hbrp_pkg::*;

   logic                 out_valid_ff, out_valid_in;
   logic                 accepted_ff, accepted_in;
   logic [SIZE_BITS-1:0] start_ff, start_in;
   logic [SIZE_BITS-1:0] length_ff, length_in;

   logic                 load;
   logic                 base_ok;
   logic                 s_lt_z;
   logic                 e_ge_z;
   logic                 s_gt_e;
   logic [SIZE_BITS-1:0] z_minus_s;
   logic [SIZE_BITS-1:0] e_minus_s1;
   logic [SIZE_BITS-1:0] z_minus_e;

   assign snap_ready = !out_valid_ff || out_ready;
   assign load       = snap_valid && snap_ready;

   // Compares and differences, all in parallel
   assign base_ok    = !snap.bad && snap.prefix_done && snap.dash && (snap.size != '0);
   assign s_lt_z     = snap.first_val < snap.size;
   assign e_ge_z     = snap.second_val >= snap.size;
   assign s_gt_e     = snap.first_val > snap.second_val;
   assign z_minus_s  = snap.size - snap.first_val;
   assign e_minus_s1 = snap.second_val - snap.first_val + SIZE_BITS'(1);
   assign z_minus_e  = snap.size - snap.second_val;

   // Range decision
   always_comb begin
      accepted_in = 1'b0;
      start_in    = '0;
      length_in   = '0;
      if (base_ok) begin
         if (snap.first_ne && snap.second_ne) begin
            // start-end, end clamped to the last byte
            if (!s_gt_e && s_lt_z) begin
               accepted_in = 1'b1;
               start_in    = snap.first_val;
               length_in   = e_ge_z ? z_minus_s : e_minus_s1;
            end
         end else if (snap.first_ne) begin
            // open-ended start
            if (s_lt_z) begin
               accepted_in = 1'b1;
               start_in    = snap.first_val;
               length_in   = z_minus_s;
            end
         end else if (snap.second_ne) begin
            // suffix, whole file when it covers the size
            if (snap.second_val != '0) begin
               accepted_in = 1'b1;
               start_in    = e_ge_z ? '0 : z_minus_e;
               length_in   = e_ge_z ? snap.size : snap.second_val;
            end
         end
      end
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         accepted_ff <= accepted_in;
         start_ff    <= start_in;
         length_ff   <= length_in;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_accepted = accepted_ff;
   assign out_start    = start_ff;
   assign out_length   = length_ff;

endmodule

FILE: rtl/http_byte_range_parser.sv
// Channel  Direction  Ports               Item
// req      in         req_t*  (tlast)     one header byte, byte_valid, resource_size
// rsp      out        rsp_t*              accepted, range_start, range_length
//
// One item per cycle on req while req_tready is high.
// The scan registers update on every item; a snapshot register feeds the range
// decision, whose result sits in the output register.
// Reset clears all parser state and empties both stages.
// req_tready drops only while a finished header is held behind a stalled rsp.

`include "http_byte_range_parser_defines.svh"

module http_byte_range_parser #(
   parameter int VALUE_BITS = hbrp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] byte_valid, [8:1] header_byte, [71:9] resource_size
   input  logic [hbrp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] accepted, [63:1] range_start, [126:64] range_length, [127] zero
   output logic [hbrp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import hbrp_pkg::*;

   logic                 snap_valid;
   logic                 snap_ready;
   snap_type             snap;
   logic                 accepted;
   logic [SIZE_BITS-1:0] range_start;
   logic [SIZE_BITS-1:0] range_length;

   // Per-byte scanner
   hbrp_scan #(
      .VALUE_BITS (VALUE_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .byte_valid    (req_tdata[0]),
      .header_byte   (req_tdata[8:1]),
      .last          (req_tlast),
      .resource_size (req_tdata[71:9]),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap)
   );

   // Range decision and result register
   hbrp_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_accepted (accepted),
      .out_start    (range_start),
      .out_length   (range_length)
   );

   assign rsp_tdata = {1'b0, range_length, range_start, accepted};

   // A rejected range carries zero start and length
   `HBRP_ASSERT_IMPL(a_reject_zero, clock, reset, rsp_tvalid && !accepted, (range_start == '0) && (range_length == '0), "rejected result with nonzero range")

   // An accepted range is never empty
   `HBRP_ASSERT_IMPL(a_accept_len, clock, reset, rsp_tvalid && accepted, range_length != '0, "accepted result with zero length")

   // The last item of a header always leaves a snapshot behind
   `HBRP_ASSERT_NEXT(a_last_snap, clock, reset, req_tvalid && req_tready && req_tlast, snap_valid, "last item produced no snapshot")

endmodule
